### hdl/binary_to_decimal_ascii_top_assert.svh
// Assertion macros for the binary to decimal ASCII converter.
`ifndef BINARY_TO_DECIMAL_ASCII_TOP_ASSERT_SVH
`define BINARY_TO_DECIMAL_ASCII_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define B2DA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("b2da assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define B2DA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("b2da assertion failed");

`endif

### hdl/b2da_pkg.sv
// Types and constants shared by the binary to decimal ASCII converter.
package b2da_pkg;

  localparam int NUM_W   = 16;
  localparam int CHAR_W  = 6;
  localparam int DIGIT_W = 4;
  localparam int DECADES = 5;
  localparam int DEC_W   = 3;

  localparam logic [DEC_W-1:0]   DEC_FIRST  = 3'd0;
  localparam logic [DEC_W-1:0]   DEC_UNITS  = 3'd4;
  localparam logic [CHAR_W-1:0]  ASCII_ZERO = 6'd48;
  localparam logic [DIGIT_W-1:0] DIGIT_MAX  = 4'd9;
  localparam logic [DIGIT_W-1:0] LEAD_MAX   = 4'd6;

  localparam logic [NUM_W-1:0] POW10 [DECADES] = '{
    16'd10000, 16'd1000, 16'd100, 16'd10, 16'd1
  };

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_SUB
  } state_t;

  typedef struct packed {
    logic             ge;
    logic [NUM_W-1:0] diff;
  } sub_res_t;

endpackage

### hdl/b2da_if.sv
// Valid/ready channels carrying the input value and the output characters.
interface b2da_in_if import b2da_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [NUM_W-1:0] number_in;

  modport source (output valid, output number_in, input ready);
  modport sink   (input valid, input number_in, output ready);
endinterface

interface b2da_out_if import b2da_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] digit_char;
  logic              last_digit;

  modport source (output valid, output digit_char, output last_digit, input ready);
  modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

### hdl/b2da_sub_unit.sv
// Shared compare-and-subtract unit: remainder minus the selected power of ten.
module b2da_sub_unit import b2da_pkg::*; (
  input  logic [NUM_W-1:0] rest,
  input  logic [DEC_W-1:0] decade,
  output sub_res_t         res
);

  logic [NUM_W:0] wide_diff;

  assign wide_diff = {1'b0, rest} - {1'b0, POW10[decade]};
  assign res.ge    = ~wide_diff[NUM_W];
  assign res.diff  = wide_diff[NUM_W-1:0];

endmodule

### hdl/binary_to_decimal_ascii_top.sv
// Conversion: repeated subtraction of each power of ten, one decade after another, down to units.
// A new number is accepted only when idle, after the previous one's last character is loaded.
// Output character register lets the next item start while the last one waits.
// Reset: synchronous, active low; clears sequencer state and output valid.
// Characters stall in place while the output register is full and not taken.
`include "binary_to_decimal_ascii_top_assert.svh"

module binary_to_decimal_ascii_top import b2da_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  b2da_in_if.sink   in_ch,
  b2da_out_if.source out_ch
);

  state_t             state_r, state_nxt;
  logic [NUM_W-1:0]   rest_r, rest_nxt;
  logic [DEC_W-1:0]   decade_r, decade_nxt;
  logic [DIGIT_W-1:0] digit_r, digit_nxt;
  logic               begun_r, begun_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]  out_char_r, out_char_nxt;
  logic               out_last_r, out_last_nxt;

  sub_res_t sub_res;
  logic     units;
  logic     emit;
  logic     slot_free;
  logic     load_out;
  logic     in_acc;

  b2da_sub_unit u_sub (
    .rest   (rest_r),
    .decade (decade_r),
    .res    (sub_res)
  );

  assign units     = (decade_r == DEC_UNITS);
  assign emit      = (digit_r != '0) || begun_r || units;
  assign slot_free = ~out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc    = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rest_r     <= rest_nxt;
    decade_r   <= decade_nxt;
    digit_r    <= digit_nxt;
    begun_r    <= begun_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    rest_nxt     = rest_r;
    decade_nxt   = decade_r;
    digit_nxt    = digit_r;
    begun_nxt    = begun_r;
    out_char_nxt = out_char_r;
    out_last_nxt = out_last_r;
    load_out     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          rest_nxt   = in_ch.number_in;
          decade_nxt = DEC_FIRST;
          digit_nxt  = '0;
          begun_nxt  = 1'b0;
          state_nxt  = ST_SUB;
        end
      end
      ST_SUB: begin
        if (sub_res.ge) begin
          rest_nxt  = sub_res.diff;
          digit_nxt = digit_r + 1'b1;
        end else if (!emit) begin
          decade_nxt = decade_r + 1'b1;
          digit_nxt  = '0;
        end else if (slot_free) begin
          load_out     = 1'b1;
          out_char_nxt = ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, digit_r};
          out_last_nxt = units;
          begun_nxt    = 1'b1;
          decade_nxt   = decade_r + 1'b1;
          digit_nxt    = '0;
          if (units) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.digit_char = out_char_r;
  assign out_ch.last_digit = out_last_r;

  `B2DA_ASSERT_NEXT(a_start_clean, in_acc, state_r == ST_SUB && decade_r == DEC_FIRST && digit_r == '0)
  `B2DA_ASSERT_NOW(a_digit_range, state_r == ST_SUB, digit_r <= DIGIT_MAX)
  `B2DA_ASSERT_NOW(a_lead_range, state_r == ST_SUB && decade_r == DEC_FIRST, digit_r <= LEAD_MAX)
  `B2DA_ASSERT_NOW(a_last_on_units, load_out && out_last_nxt, units && state_nxt == ST_IDLE)

endmodule
